[rtl/cci_pkg.sv]
// ----------------------------------------------------------------------------
// cci_pkg
// Shared widths, codes and types for the CO2 confinement index block.
// ----------------------------------------------------------------------------
package cci_pkg;

   // Sample counters
   localparam int COUNT_BITS = 24;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   // n + n_mid + 3*n_high stays below 4*2^COUNT_BITS
   localparam int NUM_BITS = COUNT_BITS + 2;

   // Fixed point widths
   localparam int PPM_BITS   = 16;
   localparam int FRAC_BITS  = 16;
   localparam int RATIO_BITS = FRAC_BITS + 3;  // Q3.16, 1.0 .. 4.0
   localparam int LOG_BITS   = FRAC_BITS + 2;  // Q2.16, 0 .. 2.0
   localparam int IDX_BITS   = 11;             // Q4.7
   localparam int CLASS_BITS = 3;

   // Iteration counts of the division / log unit
   localparam int DIV_STEPS = RATIO_BITS;
   localparam int SQR_STEPS = FRAC_BITS;
   localparam int STEP_BITS = 5;

   // Configuration port
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 16;
   localparam int THR_BITS      = 11;

   localparam logic [CSR_IDX_BITS-1:0] CSR_BAND_LOW         = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BAND_HIGH        = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SINGLE_LIMIT     = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_THRESH_LOW       = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_THRESH_MID       = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_THRESH_HIGH      = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_THRESH_VERY_HIGH = 3'd6;
   localparam logic [CSR_IDX_BITS-1:0] CSR_THRESH_EXTREME   = 3'd7;

   // Confinement classes
   localparam logic [CLASS_BITS-1:0] CLS_NONE      = 3'd0;
   localparam logic [CLASS_BITS-1:0] CLS_LOW       = 3'd1;
   localparam logic [CLASS_BITS-1:0] CLS_MID       = 3'd2;
   localparam logic [CLASS_BITS-1:0] CLS_HIGH      = 3'd3;
   localparam logic [CLASS_BITS-1:0] CLS_VERY_HIGH = 3'd4;
   localparam logic [CLASS_BITS-1:0] CLS_EXTREME   = 3'd5;

   // Top level sequencer
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_CALC,
      ST_CLASS,
      ST_DONE
   } cci_state_type;

   // Division / log unit sequencer
   typedef enum logic [1:0] {
      DL_IDLE,
      DL_DIV,
      DL_NORM,
      DL_SQR
   } dl_state_type;

   // Status returned by the division / log unit
   typedef struct packed {
      logic                done;
      logic [LOG_BITS-1:0] log2_q16;
   } dl_result_type;

endpackage

[rtl/cci_divlog.sv]
// ----------------------------------------------------------------------------
// cci_divlog
// Iterative unit: restoring division num*2^16/den (one quotient bit a cycle)
// followed by a truncated log2 by repeated squaring (one square a cycle).
// ----------------------------------------------------------------------------
module cci_divlog (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [cci_pkg::NUM_BITS-1:0]         num,
   input  logic [cci_pkg::COUNT_BITS-1:0]       den,
   output cci_pkg::dl_result_type               result
);

   localparam int RB = cci_pkg::RATIO_BITS;
   localparam int FB = cci_pkg::FRAC_BITS;
   localparam int CB = cci_pkg::COUNT_BITS;
   localparam logic [FB:0] ONE_Q16 = {1'b1, {FB{1'b0}}};

   cci_pkg::dl_state_type state_ff, state_in;

   logic [CB-1:0]                 rem_ff, rem_in;
   logic [CB-1:0]                 den_ff, den_in;
   logic [RB-1:0]                 dq_ff, dq_in;
   logic [FB:0]                   x_ff, x_in;
   logic [FB-1:0]                 frac_ff, frac_in;
   logic [1:0]                    ip_ff, ip_in;
   logic [cci_pkg::STEP_BITS-1:0] step_ff, step_in;
   logic                          done_ff, done_in;

   // control strobes
   logic load_op, div_step, norm_op, sqr_step, div_last, sqr_last;

   // datapath nets
   logic [CB:0]       trial;
   logic [CB:0]       diff;
   logic              q_bit;
   logic [2*FB+1:0]   sq;
   logic [FB+1:0]     sq_hi;

   assign div_last = (step_ff == cci_pkg::STEP_BITS'(cci_pkg::DIV_STEPS - 1));
   assign sqr_last = (step_ff == cci_pkg::STEP_BITS'(cci_pkg::SQR_STEPS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cci_pkg::DL_IDLE: if (start) state_in = cci_pkg::DL_DIV;
         cci_pkg::DL_DIV:  if (div_last) state_in = cci_pkg::DL_NORM;
         cci_pkg::DL_NORM: state_in = cci_pkg::DL_SQR;
         cci_pkg::DL_SQR:  if (sqr_last) state_in = cci_pkg::DL_IDLE;
         default:          state_in = cci_pkg::DL_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      load_op  = 1'b0;
      div_step = 1'b0;
      norm_op  = 1'b0;
      sqr_step = 1'b0;
      unique case (state_ff)
         cci_pkg::DL_IDLE: load_op  = start;
         cci_pkg::DL_DIV:  div_step = 1'b1;
         cci_pkg::DL_NORM: norm_op  = 1'b1;
         cci_pkg::DL_SQR:  sqr_step = 1'b1;
         default: begin
            load_op = 1'b0;
         end
      endcase
   end

   // one restoring division step: shift in next dividend bit, trial subtract
   assign trial = {rem_ff, dq_ff[RB-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign q_bit = (trial >= {1'b0, den_ff});

   // one squaring step, square truncated back to Q1.16 range
   assign sq    = {{(FB+1){1'b0}}, x_ff} * {{(FB+1){1'b0}}, x_ff};
   assign sq_hi = sq[2*FB+1:FB];

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      dq_in   = dq_ff;
      x_in    = x_ff;
      frac_in = frac_ff;
      ip_in   = ip_ff;
      step_in = step_ff;
      done_in = 1'b0;
      if (load_op) begin
         // partial remainder starts at num >> 3; quotient fits in RB bits
         rem_in  = {1'b0, num[cci_pkg::NUM_BITS-1:3]};
         dq_in   = {num[2:0], {FB{1'b0}}};
         den_in  = den;
         step_in = '0;
      end else if (div_step) begin
         rem_in  = q_bit ? diff[CB-1:0] : trial[CB-1:0];
         dq_in   = {dq_ff[RB-2:0], q_bit};
         step_in = step_ff + 1'b1;
      end else if (norm_op) begin
         // bring ratio into [1.0, 2.0), integer part of the log aside
         if (dq_ff[RB-1]) begin
            ip_in = 2'd2;
            x_in  = ONE_Q16;
         end else if (dq_ff[RB-2]) begin
            ip_in = 2'd1;
            x_in  = dq_ff[RB-2:1];
         end else begin
            ip_in = 2'd0;
            x_in  = (dq_ff[FB:0] < ONE_Q16) ? ONE_Q16 : dq_ff[FB:0];
         end
         frac_in = '0;
         step_in = '0;
      end else if (sqr_step) begin
         if (sq_hi[FB+1]) begin
            x_in    = sq_hi[FB+1:1];
            frac_in = {frac_ff[FB-2:0], 1'b1};
         end else begin
            x_in    = sq_hi[FB:0];
            frac_in = {frac_ff[FB-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         done_in = sqr_last;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cci_pkg::DL_IDLE;
         done_ff  <= 1'b0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         step_ff  <= step_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      dq_ff   <= dq_in;
      x_ff    <= x_in;
      frac_ff <= frac_in;
      ip_ff   <= ip_in;
   end

   assign result.done     = done_ff;
   assign result.log2_q16 = {ip_ff, frac_ff};

endmodule

[rtl/co2_confinement_index.sv]
// ----------------------------------------------------------------------------
// co2_confinement_index
// Confinement index of a room from a stream of CO2 samples, mapped to a class.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one CO2 sample (ppm) per transaction, valid/stall handshake.
//   rsp_ channel: one result per sample: class, class change flag, Q4.7 index
//   and a flag telling that the counters were saturated.
//   csr_ port: write-only registers (band bounds, first-sample limit and five
//   class thresholds), written by the user only while no sample is in flight;
//   the block itself does not enforce this.
// Sequence: a sample goes from acceptance to the result register through a
//   load step, the restoring division, a normalize step and the squaring
//   steps in the shared division/log unit, then the index, class and
//   output loads; the first sample skips the unit. req_stall stays high
//   until the result is loaded, so one sample is in work at a time and
//   no new sample is accepted before the last one is through; the next
//   sample may be accepted while the result waits in the output register.
// Reset: counters, previous class and registers return to defaults.
// Backpressure: while rsp_stall holds, the result waits; a following result
//   is held in its final step until the output register frees.
// ----------------------------------------------------------------------------
module co2_confinement_index (
   input  logic                                clock,
   input  logic                                reset,
   // sample input
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [cci_pkg::PPM_BITS-1:0]        req_co2_ppm,
   // result output
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [cci_pkg::CLASS_BITS-1:0]      rsp_conf_class,
   output logic                                rsp_class_changed,
   output logic [cci_pkg::IDX_BITS-1:0]        rsp_index_value,
   output logic                                rsp_counts_full,
   // register writes
   input  logic                                csr_wr_en,
   input  logic [cci_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [cci_pkg::CSR_DATA_BITS-1:0]   csr_wr_data
);

   localparam int CB = cci_pkg::COUNT_BITS;
   localparam int LB = cci_pkg::LOG_BITS;
   localparam int TB = cci_pkg::THR_BITS;
   localparam int PB = cci_pkg::PPM_BITS;

   cci_pkg::cci_state_type state_ff, state_in;

   // configuration registers
   logic [PB-1:0] band_low_ff, band_high_ff, single_limit_ff;
   logic [TB-1:0] thr_low_ff, thr_mid_ff, thr_high_ff, thr_vhigh_ff, thr_ext_ff;

   // running state
   logic [CB-1:0] total_ff, total_in;
   logic [CB-1:0] mid_ff, mid_in;
   logic [CB-1:0] high_ff, high_in;
   logic [cci_pkg::CLASS_BITS-1:0] prev_class_ff;

   // per-transaction work registers
   logic [PB-1:0]                   co2_ff;
   logic                            full_ff;
   logic [cci_pkg::IDX_BITS-1:0]    idx_ff;
   logic [cci_pkg::CLASS_BITS-1:0]  cls_ff;

   // output register
   logic                            rsp_valid_ff;
   logic [cci_pkg::CLASS_BITS-1:0]  rsp_class_ff;
   logic                            rsp_changed_ff;
   logic [cci_pkg::IDX_BITS-1:0]    rsp_idx_ff;
   logic                            rsp_full_ff;

   // control strobes
   logic accept, first_op, dl_start, idx_load, cls_load, rsp_load;
   logic out_free, first_sample, saturated;

   // arithmetic
   logic [cci_pkg::NUM_BITS-1:0]   num;
   logic [LB+1:0]                  lg5;
   logic [cci_pkg::IDX_BITS-1:0]   idx_calc;
   logic [cci_pkg::CLASS_BITS-1:0] cls_calc;
   cci_pkg::dl_result_type         dl_res;

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign first_sample = (total_ff == CB'(1));
   assign saturated    = (total_ff == cci_pkg::COUNT_MAX);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cci_pkg::ST_IDLE:  if (req_valid) state_in = cci_pkg::ST_PREP;
         cci_pkg::ST_PREP:  state_in = first_sample ? cci_pkg::ST_DONE : cci_pkg::ST_CALC;
         cci_pkg::ST_CALC:  if (dl_res.done) state_in = cci_pkg::ST_CLASS;
         cci_pkg::ST_CLASS: state_in = cci_pkg::ST_DONE;
         cci_pkg::ST_DONE:  if (out_free) state_in = cci_pkg::ST_IDLE;
         default:           state_in = cci_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_stall = 1'b1;
      accept    = 1'b0;
      first_op  = 1'b0;
      dl_start  = 1'b0;
      idx_load  = 1'b0;
      cls_load  = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         cci_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            accept    = req_valid;
         end
         cci_pkg::ST_PREP: begin
            first_op = first_sample;
            dl_start = !first_sample;
         end
         cci_pkg::ST_CALC:  idx_load = dl_res.done;
         cci_pkg::ST_CLASS: cls_load = 1'b1;
         cci_pkg::ST_DONE:  rsp_load = out_free;
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // saturating counters; a sample above the band is never mid-band
   always_comb begin
      total_in = total_ff;
      mid_in   = mid_ff;
      high_in  = high_ff;
      if (accept && !saturated) begin
         total_in = total_ff + 1'b1;
         if (req_co2_ppm > band_high_ff) begin
            high_in = high_ff + 1'b1;
         end else if (req_co2_ppm >= band_low_ff) begin
            mid_in = mid_ff + 1'b1;
         end
      end
   end

   // weighted numerator n + n_mid + 3*n_high
   assign num = cci_pkg::NUM_BITS'(total_ff) + cci_pkg::NUM_BITS'(mid_ff)
              + cci_pkg::NUM_BITS'(high_ff) + {1'b0, high_ff, 1'b0};

   cci_divlog u_divlog (
      .clock  (clock),
      .reset  (reset),
      .start  (dl_start),
      .num    (num),
      .den    (total_ff),
      .result (dl_res)
   );

   // index = (log2 * 5) >> 9
   assign lg5      = {dl_res.log2_q16, 2'b00} + {2'b00, dl_res.log2_q16};
   assign idx_calc = lg5[cci_pkg::IDX_BITS+8:9];

   // threshold chain, first match wins
   always_comb begin
      if (idx_ff < thr_low_ff) begin
         cls_calc = cci_pkg::CLS_NONE;
      end else if (idx_ff < thr_mid_ff) begin
         cls_calc = cci_pkg::CLS_LOW;
      end else if (idx_ff < thr_high_ff) begin
         cls_calc = cci_pkg::CLS_MID;
      end else if (idx_ff < thr_vhigh_ff) begin
         cls_calc = cci_pkg::CLS_HIGH;
      end else if (idx_ff < thr_ext_ff) begin
         cls_calc = cci_pkg::CLS_VERY_HIGH;
      end else begin
         cls_calc = cci_pkg::CLS_EXTREME;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= cci_pkg::ST_IDLE;
         total_ff      <= '0;
         mid_ff        <= '0;
         high_ff       <= '0;
         prev_class_ff <= cci_pkg::CLS_NONE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         mid_ff   <= mid_in;
         high_ff  <= high_in;
         if (rsp_load) begin
            prev_class_ff <= cls_ff;
            rsp_valid_ff  <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         band_low_ff     <= PB'(1000);
         band_high_ff    <= PB'(1700);
         single_limit_ff <= PB'(1700);
         thr_low_ff      <= TB'(128);
         thr_mid_ff      <= TB'(384);
         thr_high_ff     <= TB'(640);
         thr_vhigh_ff    <= TB'(896);
         thr_ext_ff      <= TB'(1152);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            cci_pkg::CSR_BAND_LOW:         band_low_ff     <= csr_wr_data;
            cci_pkg::CSR_BAND_HIGH:        band_high_ff    <= csr_wr_data;
            cci_pkg::CSR_SINGLE_LIMIT:     single_limit_ff <= csr_wr_data;
            cci_pkg::CSR_THRESH_LOW:       thr_low_ff      <= csr_wr_data[TB-1:0];
            cci_pkg::CSR_THRESH_MID:       thr_mid_ff      <= csr_wr_data[TB-1:0];
            cci_pkg::CSR_THRESH_HIGH:      thr_high_ff     <= csr_wr_data[TB-1:0];
            cci_pkg::CSR_THRESH_VERY_HIGH: thr_vhigh_ff    <= csr_wr_data[TB-1:0];
            cci_pkg::CSR_THRESH_EXTREME:   thr_ext_ff      <= csr_wr_data[TB-1:0];
            default: begin
               thr_ext_ff <= thr_ext_ff;
            end
         endcase
      end
   end

   // per-transaction payload
   always_ff @(posedge clock) begin
      if (accept) begin
         co2_ff  <= req_co2_ppm;
         full_ff <= saturated;
      end
      if (first_op) begin
         idx_ff <= '0;
         cls_ff <= (co2_ff >= single_limit_ff) ? cci_pkg::CLS_HIGH : cci_pkg::CLS_NONE;
      end else if (idx_load) begin
         idx_ff <= idx_calc;
      end else if (cls_load) begin
         cls_ff <= cls_calc;
      end
      if (rsp_load) begin
         rsp_class_ff   <= cls_ff;
         rsp_changed_ff <= (cls_ff != prev_class_ff);
         rsp_idx_ff     <= idx_ff;
         rsp_full_ff    <= full_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_conf_class    = rsp_class_ff;
   assign rsp_class_changed = rsp_changed_ff;
   assign rsp_index_value   = rsp_idx_ff;
   assign rsp_counts_full   = rsp_full_ff;

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the CO2 confinement index block.
// ----------------------------------------------------------------------------
// A queue of CO2 samples feeds a bursty driver. Every accepted transaction is
// scored by a bit-exact predictor of the sample counters, the Q3.16 ratio,
// the squaring log2 and the class chain. The monitor checks each result
// against the oldest prediction while the receiver stalls on its own
// pattern. Registers are rewritten between phases, only with no sample in
// flight, covering the extremes, an empty band and unordered thresholds.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int          QUIET_LIMIT  = 4000;   // cycles without any transaction
   localparam int          DRAIN_CYCLES = 50;     // settling time after the last result
   localparam int          RANDOM_ITEMS = 1420;
   localparam logic [63:0] ONE_Q16      = 64'd65536;

   // widths taken from the package
   localparam int CLASS_BITS    = cci_pkg::CLASS_BITS;
   localparam int IDX_BITS      = cci_pkg::IDX_BITS;
   localparam int PPM_BITS      = cci_pkg::PPM_BITS;
   localparam int THR_BITS      = cci_pkg::THR_BITS;
   localparam int LOG_BITS      = cci_pkg::LOG_BITS;
   localparam int COUNT_BITS    = cci_pkg::COUNT_BITS;
   localparam int CSR_IDX_BITS  = cci_pkg::CSR_IDX_BITS;
   localparam int CSR_DATA_BITS = cci_pkg::CSR_DATA_BITS;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = cci_pkg::COUNT_MAX;

   // one result as the block reports it
   typedef struct packed {
      logic [CLASS_BITS-1:0] cls;
      logic                  changed;
      logic [IDX_BITS-1:0]   index;
      logic                  full;
   } conf_report_type;

   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     req_valid   = 1'b0;
   logic                     req_stall;
   logic [PPM_BITS-1:0]      req_co2_ppm = '0;
   logic                     rsp_valid;
   logic                     rsp_stall   = 1'b0;
   logic [CLASS_BITS-1:0]    rsp_conf_class;
   logic                     rsp_class_changed;
   logic [IDX_BITS-1:0]      rsp_index_value;
   logic                     rsp_counts_full;
   logic                     csr_wr_en   = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index   = '0;
   logic [CSR_DATA_BITS-1:0] csr_wr_data = '0;

   // stimulus and expectations
   logic [PPM_BITS-1:0] sample_q[$];
   conf_report_type     report_q[$];
   int                  fail_count = 0;

   // register mirror, reset values
   logic [PPM_BITS-1:0] cfg_band_low     = 16'd1000;
   logic [PPM_BITS-1:0] cfg_band_high    = 16'd1700;
   logic [PPM_BITS-1:0] cfg_single_limit = 16'd1700;
   logic [THR_BITS-1:0] cfg_thr_low      = 11'd128;
   logic [THR_BITS-1:0] cfg_thr_mid      = 11'd384;
   logic [THR_BITS-1:0] cfg_thr_high     = 11'd640;
   logic [THR_BITS-1:0] cfg_thr_vhigh    = 11'd896;
   logic [THR_BITS-1:0] cfg_thr_extreme  = 11'd1152;

   // predictor state
   logic [COUNT_BITS-1:0] n_total    = '0;
   logic [COUNT_BITS-1:0] n_mid      = '0;
   logic [COUNT_BITS-1:0] n_high     = '0;
   logic [CLASS_BITS-1:0] last_class = cci_pkg::CLS_NONE;
   int                    last_index = 0;

   // driver and receiver pacing
   int gap_left   = 0;
   int burst_left = 0;
   int stall_run  = 0;
   int quiet_cycles = 0;

   co2_confinement_index dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_co2_ppm       (req_co2_ppm),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_conf_class    (rsp_conf_class),
      .rsp_class_changed (rsp_class_changed),
      .rsp_index_value   (rsp_index_value),
      .rsp_counts_full   (rsp_counts_full),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // truncated log2 of a Q3.16 ratio in 1.0 .. 4.0, Q2.16 result
   function automatic logic [LOG_BITS-1:0] ratio_log2(input logic [63:0] ratio);
      logic [63:0] x;
      logic [1:0]  int_part;
      logic [15:0] frac;
      x        = ratio;
      int_part = 2'd0;
      frac     = '0;
      if (x >= 4 * ONE_Q16) begin
         int_part = 2'd2;
         x        = ONE_Q16;
      end else if (x >= 2 * ONE_Q16) begin
         int_part = 2'd1;
         x        = x >> 1;
      end
      if (x < ONE_Q16) x = ONE_Q16;
      // each squaring yields one fraction bit
      for (int i = 0; i < 16; i++) begin
         x    = (x * x) >> 16;
         frac = frac << 1;
         if (x >= 2 * ONE_Q16) begin
            x       = x >> 1;
            frac[0] = 1'b1;
         end
      end
      return {int_part, frac};
   endfunction

   // threshold chain, checked in order so unordered thresholds behave
   function automatic logic [CLASS_BITS-1:0] index_class(input logic [IDX_BITS-1:0] idx);
      if (idx < cfg_thr_low)     return cci_pkg::CLS_NONE;
      if (idx < cfg_thr_mid)     return cci_pkg::CLS_LOW;
      if (idx < cfg_thr_high)    return cci_pkg::CLS_MID;
      if (idx < cfg_thr_vhigh)   return cci_pkg::CLS_HIGH;
      if (idx < cfg_thr_extreme) return cci_pkg::CLS_VERY_HIGH;
      return cci_pkg::CLS_EXTREME;
   endfunction

   // count one sample and work out the result it causes
   function automatic conf_report_type score_sample(input logic [PPM_BITS-1:0] ppm);
      conf_report_type rep;
      logic [63:0]     num;
      logic [63:0]     ratio;
      logic [63:0]     lg;
      rep.index = '0;
      rep.full  = 1'b0;
      if (n_total == COUNT_MAX) begin
         rep.full = 1'b1;
      end else begin
         n_total = n_total + 1'b1;
         if (ppm > cfg_band_high)       n_high = n_high + 1'b1;
         else if (ppm >= cfg_band_low)  n_mid  = n_mid + 1'b1;
      end
      if (n_total == 1) begin
         rep.cls = (ppm >= cfg_single_limit) ? cci_pkg::CLS_HIGH : cci_pkg::CLS_NONE;
      end else if (n_total == 0) begin
         rep.cls = cci_pkg::CLS_NONE;
      end else begin
         num   = 64'(n_total) + 64'(n_mid) + 64'd3 * 64'(n_high);
         ratio = (num << 16) / 64'(n_total);
         if (ratio > 4 * ONE_Q16) ratio = 4 * ONE_Q16;
         lg        = 64'(ratio_log2(ratio));
         rep.index = IDX_BITS'((lg * 5) >> 9);
         rep.cls   = index_class(rep.index);
      end
      rep.changed = (rep.cls != last_class);
      last_class  = rep.cls;
      last_index  = int'(rep.index);
      return rep;
   endfunction

   function automatic logic [PPM_BITS-1:0] clamp_ppm(input int v);
      if (v < 0)     return '0;
      if (v > 65535) return '1;
      return PPM_BITS'(v);
   endfunction

   function automatic int clamp_thr(input int v);
      if (v < 0)    return 0;
      if (v > 2047) return 2047;
      return v;
   endfunction

   // threshold write data with random junk above bit 10
   function automatic logic [CSR_DATA_BITS-1:0] thr_word(input int t);
      logic [4:0] junk;
      junk = 5'($urandom_range(0, 31));
      return {junk, THR_BITS'(t)};
   endfunction

   // sample shaped by the current band
   function automatic logic [PPM_BITS-1:0] next_sample(input int mode);
      int edge_ppm;
      case (mode)
         1: begin
            case ($urandom_range(0, 2))
               0:       edge_ppm = int'(cfg_band_low);
               1:       edge_ppm = int'(cfg_band_high);
               default: edge_ppm = int'(cfg_single_limit);
            endcase
            return clamp_ppm(edge_ppm + int'($urandom_range(0, 4)) - 2);
         end
         2: return (cfg_band_low == 0) ? '0 : PPM_BITS'($urandom_range(0, cfg_band_low - 1));
         3: begin
            if (cfg_band_high == '1) return '1;
            return PPM_BITS'($urandom_range(int'(cfg_band_high) + 1, 65535));
         end
         4: return PPM_BITS'($urandom_range(int'(cfg_band_low), int'(cfg_band_high)));
         default: return PPM_BITS'($urandom_range(0, 65535));
      endcase
   endfunction

   // one register write per clock; mirror follows the write
   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      case (idx)
         cci_pkg::CSR_BAND_LOW:         cfg_band_low     = value;
         cci_pkg::CSR_BAND_HIGH:        cfg_band_high    = value;
         cci_pkg::CSR_SINGLE_LIMIT:     cfg_single_limit = value;
         cci_pkg::CSR_THRESH_LOW:       cfg_thr_low      = value[THR_BITS-1:0];
         cci_pkg::CSR_THRESH_MID:       cfg_thr_mid      = value[THR_BITS-1:0];
         cci_pkg::CSR_THRESH_HIGH:      cfg_thr_high     = value[THR_BITS-1:0];
         cci_pkg::CSR_THRESH_VERY_HIGH: cfg_thr_vhigh    = value[THR_BITS-1:0];
         default:                       cfg_thr_extreme  = value[THR_BITS-1:0];
      endcase
   endtask

   task automatic program_regs(input logic [15:0] bl, input logic [15:0] bh,
                               input logic [15:0] sl, input logic [15:0] t0,
                               input logic [15:0] t1, input logic [15:0] t2,
                               input logic [15:0] t3, input logic [15:0] t4);
      write_reg(cci_pkg::CSR_BAND_LOW, bl);
      write_reg(cci_pkg::CSR_BAND_HIGH, bh);
      write_reg(cci_pkg::CSR_SINGLE_LIMIT, sl);
      write_reg(cci_pkg::CSR_THRESH_LOW, t0);
      write_reg(cci_pkg::CSR_THRESH_MID, t1);
      write_reg(cci_pkg::CSR_THRESH_HIGH, t2);
      write_reg(cci_pkg::CSR_THRESH_VERY_HIGH, t3);
      write_reg(cci_pkg::CSR_THRESH_EXTREME, t4);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // everything sent, every result back, block quiet
   task automatic wait_idle;
      @(negedge clock);
      while (sample_q.size() != 0 || req_valid || report_q.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // driver: bursts of samples with random gaps, scoring each transaction
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         gap_left   <= 0;
         burst_left <= 0;
      end else begin
         if (req_valid && !req_stall) report_q = {report_q, score_sample(req_co2_ppm)};
         if (!req_valid || !req_stall) begin
            if (gap_left != 0) begin
               gap_left  <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (sample_q.size() != 0) begin
               req_valid   <= 1'b1;
               req_co2_ppm <= sample_q.pop_front();
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 24);
                  gap_left   <= ($urandom_range(0, 2) == 0) ? $urandom_range(1, 64) : 0;
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: free stretches, long holds and short random flicker
   always @(posedge clock) begin
      if (stall_run == 0) begin
         case ($urandom_range(0, 3))
            0: begin
               rsp_stall <= 1'b0;
               stall_run <= $urandom_range(50, 300);
            end
            1: begin
               rsp_stall <= 1'b1;
               stall_run <= $urandom_range(1, 80);
            end
            default: begin
               rsp_stall <= 1'($urandom_range(0, 1));
               stall_run <= $urandom_range(1, 6);
            end
         endcase
      end else begin
         stall_run <= stall_run - 1;
      end
   end

   // monitor: compare each result transaction with the oldest prediction
   always @(posedge clock) begin : result_check
      conf_report_type got;
      conf_report_type want;
      got = {rsp_conf_class, rsp_class_changed, rsp_index_value, rsp_counts_full};
      if (!reset && rsp_valid && !rsp_stall) begin
         if (report_q.size() == 0) begin
            if (fail_count < 10)
               $display("%0t: result with none pending: cls=%0d chg=%0d idx=%0d full=%0d",
                        $time, got.cls, got.changed, got.index, got.full);
            fail_count++;
         end else begin
            want = report_q.pop_front();
            if (got.cls !== want.cls || got.changed !== want.changed ||
                got.index !== want.index || got.full !== want.full) begin
               if (fail_count < 10) begin
                  $display("%0t: exp cls=%0d chg=%0d idx=%0d full=%0d",
                           $time, want.cls, want.changed, want.index, want.full);
                  $display("%0t: got cls=%0d chg=%0d idx=%0d full=%0d",
                           $time, got.cls, got.changed, got.index, got.full);
               end
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles with no transaction anywhere
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int issued;
      int phase_len;
      int mode;
      int span;
      int t0, t1, t2, t3, t4;
      logic [15:0] bl, bh, sl;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed, reset register values: first sample above the limit, then
      // all-high samples (ratio of exactly 4.0) and every band edge
      @(negedge clock);
      sample_q = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd999, 16'd1000, 16'd1001,
                   16'd1699, 16'd1700, 16'd1701, 16'd0, 16'd0, 16'd1, 16'd32768,
                   16'hFFFE, 16'd1700, 16'd1000, 16'd0, 16'hFFFF};
      wait_idle();

      // widest band, zero thresholds: every sample mid, class extreme
      program_regs(16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      @(negedge clock);
      repeat (6) sample_q = {sample_q, next_sample(0)};
      wait_idle();

      // empty band, thresholds at the top through the masked upper bits
      program_regs(16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                   16'hFFFF, 16'hFFFF);
      @(negedge clock);
      sample_q = {sample_q, 16'd0};
      repeat (5) sample_q = {sample_q, next_sample(0)};
      wait_idle();

      // random phases, each with its own registers and sample mix
      issued = 0;
      while (issued < RANDOM_ITEMS) begin
         case ($urandom_range(0, 7))
            0: begin
               bl = 16'd0;
               bh = 16'hFFFF;
            end
            1: begin
               bl = 16'($urandom_range(1000, 65535));
               bh = 16'($urandom_range(0, int'(bl) - 1));
            end
            2: begin
               bl = 16'($urandom_range(0, 65535));
               bh = bl;
            end
            default: begin
               bl = 16'($urandom_range(300, 1500));
               bh = bl + 16'($urandom_range(0, 1500));
            end
         endcase
         sl = 16'($urandom_range(0, 65535));
         if ($urandom_range(0, 5) == 0) begin
            // unordered thresholds
            t0 = $urandom_range(0, 2047);
            t1 = $urandom_range(0, 2047);
            t2 = $urandom_range(0, 2047);
            t3 = $urandom_range(0, 2047);
            t4 = $urandom_range(0, 2047);
         end else begin
            // ascending thresholds straddling the present index
            span = $urandom_range(4, 64);
            t0 = clamp_thr(last_index - 2 * span + int'($urandom_range(0, span)));
            t1 = clamp_thr(t0 + int'($urandom_range(0, span)));
            t2 = clamp_thr(t1 + int'($urandom_range(0, span)));
            t3 = clamp_thr(t2 + int'($urandom_range(0, span)));
            t4 = clamp_thr(t3 + int'($urandom_range(0, span)));
         end
         program_regs(bl, bh, sl, thr_word(t0), thr_word(t1), thr_word(t2),
                      thr_word(t3), thr_word(t4));

         phase_len = $urandom_range(60, 140);
         mode      = $urandom_range(0, 5);
         @(negedge clock);
         for (int k = 0; k < phase_len; k++) begin
            // mode 5 mixes all sample shapes
            if (mode == 5) sample_q = {sample_q, next_sample($urandom_range(0, 4))};
            else           sample_q = {sample_q, next_sample(mode)};
         end
         issued += phase_len;
         wait_idle();
      end

      if (report_q.size() != 0) fail_count++;
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
